### rtl/core/tcg_pkg.sv
// Shared constants, codes and types of the text-mode character generator.
`timescale 1ns / 1ps

package tcg_pkg;

  localparam int COLUMNS_DEF    = 80;
  localparam int LINES_DEF      = 200;
  localparam int TEXT_DEPTH_DEF = 4096;
  localparam int FONT_DEPTH     = 2048;
  localparam int FONT_AW        = $clog2(FONT_DEPTH);

  localparam int GLYPH_ROWS = 8;
  localparam int GLYPH_W    = 8;
  localparam int ROW_SEL_W  = $clog2(GLYPH_ROWS);
  localparam int PIX_SEL_W  = $clog2(GLYPH_W);
  localparam int BYTE_W     = 8;
  localparam int PAL_DEPTH  = 16;
  localparam int PAL_AW     = $clog2(PAL_DEPTH);
  localparam int PIX_W      = 16;

  localparam int KIND_W   = 2;
  localparam int ADDR_W   = 12;
  localparam int WDATA_W  = 16;
  localparam int COLUMN_W = 7;
  localparam int LINE_W   = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_TEXT   = 2'd0,
    KIND_FONT   = 2'd1,
    KIND_PAL    = 2'd2,
    KIND_RENDER = 2'd3
  } kind_e;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] idx;
    logic [PIX_W-1:0]  data;
  } pal_wr_t;

  typedef struct packed {
    logic              valid;
    logic [PAL_AW-1:0] idx;
    logic              last;
  } shade_req_t;

endpackage

### rtl/core/tcg_if.sv
// Handshake interfaces for command beats and pixel beats.
`timescale 1ns / 1ps

interface tcg_in_if;
  logic                          valid;
  logic                          ready;
  logic [tcg_pkg::KIND_W-1:0]    kind;
  logic [tcg_pkg::ADDR_W-1:0]    addr;
  logic [tcg_pkg::WDATA_W-1:0]   wdata;
  logic [tcg_pkg::COLUMN_W-1:0]  column;
  logic [tcg_pkg::LINE_W-1:0]    line;

  modport source (output valid, kind, addr, wdata, column, line, input ready);
  modport sink   (input valid, kind, addr, wdata, column, line, output ready);
endinterface

interface tcg_out_if;
  logic                       valid;
  logic                       ready;
  logic [tcg_pkg::PIX_W-1:0]  pixel;
  logic                       last;

  modport source (output valid, pixel, last, input ready);
  modport sink   (input valid, pixel, last, output ready);
endinterface

### rtl/core/tcg_shade.sv
// Color table and registered pixel output stage.
`timescale 1ns / 1ps

module tcg_shade (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tcg_pkg::pal_wr_t     pal_wr_i,
  input  tcg_pkg::shade_req_t  req_i,
  output logic                 ready_o,
  tcg_out_if.source            pix_o
);

  logic [tcg_pkg::PIX_W-1:0] color_table [tcg_pkg::PAL_DEPTH];
  logic                      valid_q;
  logic [tcg_pkg::PIX_W-1:0] pixel_q;
  logic                      last_q;

  assign ready_o     = !valid_q || pix_o.ready;
  assign pix_o.valid = valid_q;
  assign pix_o.pixel = pixel_q;
  assign pix_o.last  = last_q;

  always_ff @(posedge clk_i) begin
    if (pal_wr_i.en) begin
      color_table[pal_wr_i.idx] <= pal_wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && req_i.valid) begin
      pixel_q <= color_table[req_i.idx];
      last_q  <= req_i.last;
    end
  end

endmodule

### rtl/core/text_mode_character_generator.sv
// Top level of the text-mode character generator.
`timescale 1ns / 1ps

// Write beats (text byte, font byte, palette entry) are written when taken. A render
// beat first reads the character byte, attribute byte and font row, in that order,
// from the synchronous text and font memories, then emits eight pixels, one per
// cycle while the output takes them, last flagged on the eighth. A render beat
// outside the screen is dropped. The pixel output register lets the next command
// be taken while the last pixel still waits. TEXT_DEPTH must be a power of two;
// the block itself does not check it. Memory contents are undefined until written.
module text_mode_character_generator #(
  parameter int COLUMNS    = tcg_pkg::COLUMNS_DEF,
  parameter int LINES      = tcg_pkg::LINES_DEF,
  parameter int TEXT_DEPTH = tcg_pkg::TEXT_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcg_in_if.sink     req_i,
  tcg_out_if.source  pix_o
);

  localparam int TEXT_AW   = $clog2(TEXT_DEPTH);
  localparam int ROW_BYTES = COLUMNS * 2;
  localparam int BASE_W    = 16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ATTR,
    S_GLYPH,
    S_EMIT
  } state_e;

  state_e                             state_q;
  logic [TEXT_AW-1:0]                 base_q;
  logic [tcg_pkg::ROW_SEL_W-1:0]      row_q;
  logic [tcg_pkg::BYTE_W-1:0]         ch_q;
  logic [tcg_pkg::BYTE_W-1:0]         attr_q;
  logic [tcg_pkg::PIX_SEL_W-1:0]      pix_cnt_q;

  logic [tcg_pkg::BYTE_W-1:0] text_mem [TEXT_DEPTH];
  logic [tcg_pkg::BYTE_W-1:0] font_mem [tcg_pkg::FONT_DEPTH];
  logic [tcg_pkg::BYTE_W-1:0] text_rdata_q;
  logic [tcg_pkg::BYTE_W-1:0] font_rdata_q;

  logic                         accept;
  tcg_pkg::kind_e               kind;
  logic                         on_screen;
  logic [BASE_W-1:0]            base;
  logic                         text_we;
  logic                         font_we;
  logic                         text_re;
  logic [TEXT_AW-1:0]           text_raddr;
  logic                         font_re;
  logic [tcg_pkg::FONT_AW-1:0]  font_raddr;
  logic                         pix_on;
  tcg_pkg::pal_wr_t             pal_wr;
  tcg_pkg::shade_req_t          shade_req;
  logic                         shade_ready;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign kind        = tcg_pkg::kind_e'(req_i.kind);

  assign on_screen = (32'(req_i.column) < COLUMNS) && (32'(req_i.line) < LINES);
  assign base      = BASE_W'(req_i.line[tcg_pkg::LINE_W-1:tcg_pkg::ROW_SEL_W])
                     * BASE_W'(ROW_BYTES)
                   + BASE_W'({req_i.column, 1'b0});

  assign text_we = accept && (kind == tcg_pkg::KIND_TEXT);
  assign font_we = accept && (kind == tcg_pkg::KIND_FONT);

  assign pal_wr.en   = accept && (kind == tcg_pkg::KIND_PAL);
  assign pal_wr.idx  = req_i.addr[tcg_pkg::PAL_AW-1:0];
  assign pal_wr.data = req_i.wdata;

  always_comb begin
    text_re    = 1'b0;
    text_raddr = base[TEXT_AW-1:0];
    if (accept && (kind == tcg_pkg::KIND_RENDER) && on_screen) begin
      text_re = 1'b1;
    end else if (state_q == S_ATTR) begin
      text_re    = 1'b1;
      text_raddr = base_q + TEXT_AW'(1);
    end
  end

  assign font_re    = (state_q == S_GLYPH);
  assign font_raddr = {ch_q, row_q};

  always_ff @(posedge clk_i) begin
    if (text_we) begin
      text_mem[TEXT_AW'(req_i.addr)] <= req_i.wdata[tcg_pkg::BYTE_W-1:0];
    end
    if (text_re) begin
      text_rdata_q <= text_mem[text_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (font_we) begin
      font_mem[req_i.addr[tcg_pkg::FONT_AW-1:0]] <= req_i.wdata[tcg_pkg::BYTE_W-1:0];
    end
    if (font_re) begin
      font_rdata_q <= font_mem[font_raddr];
    end
  end

  assign pix_on          = (ch_q != '0) && font_rdata_q[pix_cnt_q];
  assign shade_req.valid = (state_q == S_EMIT);
  assign shade_req.idx   = pix_on ? attr_q[tcg_pkg::PAL_AW-1:0]
                                  : attr_q[tcg_pkg::BYTE_W-1:tcg_pkg::PAL_AW];
  assign shade_req.last  = (pix_cnt_q == tcg_pkg::PIX_SEL_W'(tcg_pkg::GLYPH_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pix_cnt_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          pix_cnt_q <= '0;
          if (text_re) begin
            state_q <= S_ATTR;
          end
        end
        S_ATTR: begin
          state_q <= S_GLYPH;
        end
        S_GLYPH: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (shade_ready) begin
            pix_cnt_q <= pix_cnt_q + tcg_pkg::PIX_SEL_W'(1);
            if (shade_req.last) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_re && (state_q == S_IDLE)) begin
      base_q <= base[TEXT_AW-1:0];
      row_q  <= req_i.line[tcg_pkg::ROW_SEL_W-1:0];
    end
    if (state_q == S_ATTR) begin
      ch_q <= text_rdata_q;
    end
    if (state_q == S_GLYPH) begin
      attr_q <= text_rdata_q;
    end
  end

  tcg_shade u_shade (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pal_wr_i (pal_wr),
    .req_i    (shade_req),
    .ready_o  (shade_ready),
    .pix_o    (pix_o)
  );

endmodule
